@@ hdl/ddalr_pkg.sv @@
// Shared types and constants for the DDA line rasterizer.
package ddalr_pkg;

  localparam int unsigned COORD_BITS = 10;
  localparam int unsigned OSF_BITS = 8;
  localparam int unsigned CNT_BITS = COORD_BITS + OSF_BITS;
  localparam logic [OSF_BITS-1:0] OSF_RESET = 8'd100;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef struct packed {
    logic                  command;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
  } ddalr_in_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  last_pixel;
  } ddalr_out_t;

  typedef struct packed {
    logic start;
    logic emit;
    logic mul;
    logic div_step;
    logic zero_line;
    logic finish;
  } ddalr_cmd_t;

  typedef struct packed {
    logic line_active;
    logic count_zero;
  } ddalr_status_t;

endpackage

@@ hdl/ddalr_datapath.sv @@
// Datapath: endpoint setup, step-count multiply, two restoring dividers, position stepping.
module ddalr_datapath #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ddalr_pkg::ddalr_cmd_t               cmd_i,
  input  ddalr_pkg::ddalr_in_t                in_data_i,
  input  logic [ddalr_pkg::OSF_BITS-1:0]      osf_i,
  output ddalr_pkg::ddalr_status_t            status_o,
  output ddalr_pkg::ddalr_out_t               out_data_o
);
  import ddalr_pkg::*;

  localparam int unsigned POS_W = COORD_BITS + FRAC_BITS + 1;
  localparam int unsigned STEP_W = FRAC_BITS + 2;
  localparam int unsigned DIV_W = COORD_BITS + FRAC_BITS;
  localparam logic [POS_W-1:0] HALF = POS_W'(1) << (FRAC_BITS - 1);

  logic [COORD_BITS-1:0] adx_q, ady_q, len_q;
  logic                  negx_q, negy_q;
  logic [CNT_BITS-1:0]   count_q;
  logic [CNT_BITS-1:0]   rem_x_q, rem_y_q;
  logic [DIV_W-1:0]      quo_x_q, quo_y_q;
  logic [POS_W-1:0]      pos_x_q, pos_y_q;
  logic [STEP_W-1:0]     step_x_q, step_y_q;
  logic [CNT_BITS-1:0]   steps_left_q;
  ddalr_out_t            out_q;

  logic [COORD_BITS-1:0] adx, ady;
  logic [CNT_BITS:0]     trial_x, trial_y, divisor;
  logic                  ge_x, ge_y;
  logic [CNT_BITS-1:0]   rem_x_d, rem_y_d;
  logic [STEP_W-1:0]     qx, qy;
  logic [POS_W-1:0]      rnd_x, rnd_y;

  assign adx = (in_data_i.x_end >= in_data_i.x_start) ?
               in_data_i.x_end - in_data_i.x_start : in_data_i.x_start - in_data_i.x_end;
  assign ady = (in_data_i.y_end >= in_data_i.y_start) ?
               in_data_i.y_end - in_data_i.y_start : in_data_i.y_start - in_data_i.y_end;

  assign divisor = {1'b0, count_q};
  assign trial_x = {rem_x_q, quo_x_q[DIV_W-1]};
  assign trial_y = {rem_y_q, quo_y_q[DIV_W-1]};
  assign ge_x = trial_x >= divisor;
  assign ge_y = trial_y >= divisor;
  assign rem_x_d = ge_x ? CNT_BITS'(trial_x - divisor) : trial_x[CNT_BITS-1:0];
  assign rem_y_d = ge_y ? CNT_BITS'(trial_y - divisor) : trial_y[CNT_BITS-1:0];

  assign qx = quo_x_q[STEP_W-1:0];
  assign qy = quo_y_q[STEP_W-1:0];

  assign rnd_x = pos_x_q + HALF;
  assign rnd_y = pos_y_q + HALF;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_left_q <= '0;
    end else if (cmd_i.start) begin
      steps_left_q <= '0;
    end else if (cmd_i.finish) begin
      steps_left_q <= count_q;
    end else if (cmd_i.emit) begin
      steps_left_q <= steps_left_q - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      adx_q   <= adx;
      ady_q   <= ady;
      len_q   <= (adx > ady) ? adx : ady;
      negx_q  <= in_data_i.x_end < in_data_i.x_start;
      negy_q  <= in_data_i.y_end < in_data_i.y_start;
      pos_x_q <= {1'b0, in_data_i.x_start, {FRAC_BITS{1'b0}}};
      pos_y_q <= {1'b0, in_data_i.y_start, {FRAC_BITS{1'b0}}};
    end
    if (cmd_i.mul) begin
      count_q <= {{OSF_BITS{1'b0}}, len_q} * {{COORD_BITS{1'b0}}, osf_i};
      rem_x_q <= '0;
      rem_y_q <= '0;
      quo_x_q <= {adx_q, {FRAC_BITS{1'b0}}};
      quo_y_q <= {ady_q, {FRAC_BITS{1'b0}}};
    end
    if (cmd_i.div_step) begin
      rem_x_q <= rem_x_d;
      rem_y_q <= rem_y_d;
      quo_x_q <= {quo_x_q[DIV_W-2:0], ge_x};
      quo_y_q <= {quo_y_q[DIV_W-2:0], ge_y};
    end
    if (cmd_i.zero_line) begin
      step_x_q <= '0;
      step_y_q <= '0;
    end else if (cmd_i.finish) begin
      step_x_q <= negx_q ? STEP_W'(0) - qx : qx;
      step_y_q <= negy_q ? STEP_W'(0) - qy : qy;
    end
    if (cmd_i.emit) begin
      out_q.pixel_x    <= rnd_x[FRAC_BITS +: COORD_BITS];
      out_q.pixel_y    <= rnd_y[FRAC_BITS +: COORD_BITS];
      out_q.last_pixel <= steps_left_q == CNT_BITS'(1);
      pos_x_q <= pos_x_q + {{(POS_W-STEP_W){step_x_q[STEP_W-1]}}, step_x_q};
      pos_y_q <= pos_y_q + {{(POS_W-STEP_W){step_y_q[STEP_W-1]}}, step_y_q};
    end
  end

  assign status_o.line_active = steps_left_q != '0;
  assign status_o.count_zero  = count_q == '0;
  assign out_data_o = out_q;

endmodule

@@ hdl/ddalr_ctrl.sv @@
// Controller: handshakes, line setup sequencing and divider iteration count.
module ddalr_ctrl #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      in_command_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  input  ddalr_pkg::ddalr_status_t  status_i,
  output ddalr_pkg::ddalr_cmd_t     cmd_o
);
  import ddalr_pkg::*;

  localparam int unsigned DIV_W = COORD_BITS + FRAC_BITS;
  localparam int unsigned ITER_W = $clog2(DIV_W);
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(DIV_W - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e            state_q;
  logic [ITER_W-1:0] iter_q;
  logic              out_valid_q;
  logic              in_xfer;

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o           = '0;
    cmd_o.start     = in_xfer && (in_command_i == CMD_START);
    cmd_o.emit      = in_xfer && (in_command_i == CMD_STEP) && status_i.line_active;
    cmd_o.mul       = state_q == ST_MUL;
    cmd_o.div_step  = (state_q == ST_DIV) && !status_i.count_zero;
    cmd_o.zero_line = (state_q == ST_DIV) && status_i.count_zero;
    cmd_o.finish    = state_q == ST_FIN;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_o.start) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          iter_q  <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (status_i.count_zero) begin
            state_q <= ST_IDLE;
          end else if (iter_q == ITER_LAST) begin
            state_q <= ST_FIN;
          end else begin
            iter_q <= iter_q + ITER_W'(1);
          end
        end
        ST_FIN: begin
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ hdl/dda_line_rasterizer_top.sv @@
// A step transfer on an active line has its pixel registered in the output register.
// Throughput: step transfers go in every cycle on an active line unless the output stalls.
// A start transfer holds in_ready_o low through the multiply, bit-serial restoring divide
// and finish states; with a zero step count, the divide state returns straight to idle.
// Reset (async, active low) clears the active line and sets oversample_factor to 100.
module dda_line_rasterizer_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ddalr_pkg::ddalr_in_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ddalr_pkg::ddalr_out_t out_data_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import ddalr_pkg::*;

  logic [OSF_BITS-1:0] osf_q;
  ddalr_cmd_t          cmd;
  ddalr_status_t       status;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {{(32-OSF_BITS){1'b0}}, osf_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      osf_q <= OSF_RESET;
    end else if (cfg_wr) begin
      osf_q <= pwdata[OSF_BITS-1:0];
    end
  end

  ddalr_ctrl #(
    .FRAC_BITS(FRAC_BITS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_command_i (in_data_i.command),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  ddalr_datapath #(
    .FRAC_BITS(FRAC_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .osf_i      (osf_q),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

  a_start_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start |=> !in_ready_o)
    else $error("input taken during line setup");

  a_idle_step_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_data_i.command == CMD_STEP && !status.line_active)
    |=> !out_valid_o)
    else $error("pixel produced with no active line");

  a_last_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && out_data_o.last_pixel) |=> !status.line_active)
    else $error("line still active after last pixel");

  a_single_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.start, cmd.emit, cmd.mul, cmd.div_step, cmd.zero_line, cmd.finish}))
    else $error("conflicting datapath commands");

endmodule

@@ dv/ddalr_pixel_checker.sv @@
// Pixel predictor and scoreboard for the DDA line rasterizer testbench.
module ddalr_pixel_checker #(
  parameter int unsigned FRAC_BITS = 16,
  parameter logic [2:0]  OSF_ADDR  = 3'd0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  ddalr_pkg::ddalr_in_t  in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  ddalr_pkg::ddalr_out_t out_data_i,
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic                  pready_i,
  input  logic [2:0]            paddr_i,
  input  logic [31:0]           pwdata_i,
  output int                    pixels_due_o,
  output int                    fail_count_o
);
  import ddalr_pkg::*;

  localparam int unsigned POS_W = COORD_BITS + FRAC_BITS + 1;
  localparam int unsigned STEP_W = FRAC_BITS + 2;

  logic [OSF_BITS-1:0]   osf;
  logic [POS_W-1:0]      pos_x, pos_y;
  logic [STEP_W-1:0]     inc_x, inc_y;
  logic [CNT_BITS-1:0]   pixels_left;
  logic [CNT_BITS-1:0]   line_steps;
  logic [COORD_BITS-1:0] dx_abs, dy_abs, major_len;
  ddalr_out_t            pixel_queue[$];
  ddalr_out_t            due, seen;
  int                    fails = 0;

  // Signed per-step increment: truncated magnitude, then the sign of the delta.
  function automatic logic [STEP_W-1:0] sub_step(input logic [COORD_BITS-1:0] from_c,
                                                 input logic [COORD_BITS-1:0] to_c,
                                                 input logic [CNT_BITS-1:0] steps);
    longint unsigned mag;
    logic [STEP_W-1:0] q;
    mag = (to_c < from_c) ? longint'(from_c - to_c) : longint'(to_c - from_c);
    q = STEP_W'((mag << FRAC_BITS) / longint'(steps));
    return (to_c < from_c) ? -q : q;
  endfunction

  function automatic logic [COORD_BITS-1:0] round_coord(input logic [POS_W-1:0] p);
    logic [POS_W-1:0] s;
    s = p + (POS_W'(1) << (FRAC_BITS - 1));
    return s[FRAC_BITS +: COORD_BITS];
  endfunction

  function automatic logic [POS_W-1:0] advance(input logic [POS_W-1:0] p,
                                               input logic [STEP_W-1:0] inc);
    return p + {{(POS_W-STEP_W){inc[STEP_W-1]}}, inc};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      osf = OSF_RESET;
      pos_x = '0;
      pos_y = '0;
      inc_x = '0;
      inc_y = '0;
      pixels_left = '0;
      pixel_queue.delete();
      pixels_due_o <= 0;
      fail_count_o <= fails;
    end else begin
      if (out_valid_i && out_ready_i) begin
        seen = out_data_i;
        if (pixel_queue.size() == 0) begin
          $error("unexpected pixel transfer: x=%0d y=%0d last=%0d",
                 seen.pixel_x, seen.pixel_y, seen.last_pixel);
          fails++;
        end else begin
          due = pixel_queue.pop_front();
          if (seen.pixel_x !== due.pixel_x) begin
            $error("pixel_x: expected %0d, got %0d", due.pixel_x, seen.pixel_x);
            fails++;
          end
          if (seen.pixel_y !== due.pixel_y) begin
            $error("pixel_y: expected %0d, got %0d", due.pixel_y, seen.pixel_y);
            fails++;
          end
          if (seen.last_pixel !== due.last_pixel) begin
            $error("last_pixel: expected %0d, got %0d", due.last_pixel, seen.last_pixel);
            fails++;
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        if (in_data_i.command == CMD_START) begin
          dx_abs = (in_data_i.x_end >= in_data_i.x_start) ?
                   in_data_i.x_end - in_data_i.x_start : in_data_i.x_start - in_data_i.x_end;
          dy_abs = (in_data_i.y_end >= in_data_i.y_start) ?
                   in_data_i.y_end - in_data_i.y_start : in_data_i.y_start - in_data_i.y_end;
          major_len = (dx_abs > dy_abs) ? dx_abs : dy_abs;
          line_steps = CNT_BITS'(major_len) * CNT_BITS'(osf);
          pos_x = POS_W'(in_data_i.x_start) << FRAC_BITS;
          pos_y = POS_W'(in_data_i.y_start) << FRAC_BITS;
          if (line_steps != 0) begin
            inc_x = sub_step(in_data_i.x_start, in_data_i.x_end, line_steps);
            inc_y = sub_step(in_data_i.y_start, in_data_i.y_end, line_steps);
          end else begin
            inc_x = '0;
            inc_y = '0;
          end
          pixels_left = line_steps;
        end else if (pixels_left != 0) begin
          due.pixel_x = round_coord(pos_x);
          due.pixel_y = round_coord(pos_y);
          due.last_pixel = (pixels_left == 1);
          pixel_queue.push_back(due);
          pos_x = advance(pos_x, inc_x);
          pos_y = advance(pos_y, inc_y);
          pixels_left = pixels_left - 1'b1;
        end
      end

      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == OSF_ADDR)
        osf = pwdata_i[OSF_BITS-1:0];

      pixels_due_o <= pixel_queue.size();
      fail_count_o <= fails;
    end
  end

endmodule

@@ dv/dda_line_rasterizer_top_tb.sv @@
// Testbench top for the DDA line rasterizer: stimulus, handshake pacing and verdict.
module dda_line_rasterizer_top_tb;
  import ddalr_pkg::*;

  localparam int unsigned FRAC_BITS = 16;
  localparam logic [2:0] OSF_ADDR = 3'd0;
  localparam int unsigned PHASE_ITEMS = 24;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam logic [COORD_BITS-1:0] C_MAX = '1;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  ddalr_in_t   in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  ddalr_out_t  out_data_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int          pixels_due;
  int          fail_count;
  int          items_sent = 0;
  int          quiet_cycles = 0;
  int          osf_setting = OSF_RESET;
  bit          idle_on = 1'b1;
  int          osf_plan[9] = '{2, 1, 7, 255, 3, 0, 100, 0, 0};

  dda_line_rasterizer_top #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  ddalr_pixel_checker #(.FRAC_BITS(FRAC_BITS), .OSF_ADDR(OSF_ADDR)) u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .pready_i(pready),
    .paddr_i(paddr), .pwdata_i(pwdata),
    .pixels_due_o(pixels_due), .fail_count_o(fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver pacing.
  initial begin
    int gap;
    out_ready_i = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      gap = idle_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  task automatic send_item(input logic cmd, input logic [COORD_BITS-1:0] xs,
                           input logic [COORD_BITS-1:0] ys, input logic [COORD_BITS-1:0] xe,
                           input logic [COORD_BITS-1:0] ye);
    int gap;
    ddalr_in_t item;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    item.command = cmd;
    item.x_start = xs;
    item.y_start = ys;
    item.x_end = xe;
    item.y_end = ye;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= item;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    items_sent++;
  endtask

  task automatic start_line(input logic [COORD_BITS-1:0] xs, input logic [COORD_BITS-1:0] ys,
                            input logic [COORD_BITS-1:0] xe, input logic [COORD_BITS-1:0] ye);
    send_item(CMD_START, xs, ys, xe, ye);
  endtask

  // Endpoint fields of step transfers are ignored, so they carry noise.
  task automatic step_line(input int n);
    repeat (n) send_item(CMD_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
                         COORD_BITS'($urandom), COORD_BITS'($urandom));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pixels_due != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_oversample(input int value);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= OSF_ADDR;
    pwdata <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    osf_setting = value;
  endtask

  function automatic logic [COORD_BITS-1:0] offset_coord(input logic [COORD_BITS-1:0] c,
                                                         input int d);
    int t;
    t = int'(c) + d;
    if (t < 0 || t > int'(C_MAX)) t = int'(c) - d;
    return COORD_BITS'(t);
  endfunction

  task automatic random_sequence();
    int kind, cap, len, minor_len, dx, dy, n;
    logic [COORD_BITS-1:0] xs, ys;
    kind = $urandom_range(0, 9);
    xs = COORD_BITS'($urandom);
    ys = COORD_BITS'($urandom);
    cap = (osf_setting == 0) ? 20 : 96 / osf_setting;
    if (kind <= 5 && cap == 0) kind = 6;
    if (kind <= 5) begin
      // short line run to its end, plus up to two steps past it
      len = $urandom_range(0, cap);
      minor_len = $urandom_range(0, len);
      dx = $urandom_range(0, 1) ? len : minor_len;
      dy = (dx == len && $urandom_range(0, 1)) ? minor_len : len;
      if ($urandom_range(0, 1)) dx = -dx;
      if ($urandom_range(0, 1)) dy = -dy;
      start_line(xs, ys, offset_coord(xs, dx), offset_coord(ys, dy));
      n = len * osf_setting + $urandom_range(0, 2);
      if (osf_setting == 0) n = $urandom_range(1, 3);
      step_line(n);
    end else if (kind <= 7) begin
      start_line(xs, ys, COORD_BITS'($urandom), COORD_BITS'($urandom));
      step_line($urandom_range(0, 12));
    end else if (kind == 8) begin
      step_line($urandom_range(1, 3));
    end else begin
      start_line(xs, ys, COORD_BITS'($urandom), COORD_BITS'($urandom));
      step_line($urandom_range(0, 2));
      start_line(COORD_BITS'($urandom), COORD_BITS'($urandom),
                 COORD_BITS'($urandom), COORD_BITS'($urandom));
      step_line($urandom_range(1, 6));
    end
  endtask

  initial begin
    int target;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset oversampling
    step_line(1);
    start_line('0, '0, C_MAX, C_MAX);
    step_line(2);
    start_line(C_MAX, C_MAX, '0, '0);
    step_line(2);
    start_line(C_MAX, '0, '0, C_MAX);
    step_line(1);
    start_line(10'd5, 10'd5, 10'd5, 10'd5);
    step_line(1);

    set_oversample(1);
    start_line('0, C_MAX, 10'd3, 10'd1021);
    step_line(4);
    start_line(C_MAX, '0, 10'd1020, 10'd2);
    step_line(1);
    start_line(10'd512, 10'd512, 10'd510, 10'd511);
    step_line(3);

    set_oversample(0);
    start_line('0, '0, 10'd100, 10'd50);
    step_line(2);

    osf_plan[7] = $urandom_range(1, 255);
    osf_plan[8] = $urandom_range(1, 255);
    target = items_sent;
    foreach (osf_plan[i]) begin
      set_oversample(osf_plan[i]);
      idle_on = ($urandom_range(0, 3) != 0);
      target += PHASE_ITEMS;
      while (items_sent < target) random_sequence();
    end

    drain();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/ddalr_pkg.sv
hdl/ddalr_datapath.sv
hdl/ddalr_ctrl.sv
hdl/dda_line_rasterizer_top.sv
dv/ddalr_pixel_checker.sv
dv/dda_line_rasterizer_top_tb.sv
